// ===== hw/rtl/bmpu_pkg.sv =====
// Shared types and constants for the banked memory paging unit.
`timescale 1ns / 1ps
`default_nettype none

package bmpu_pkg;

    // Memory geometry
    localparam int RAM_BANKS  = 8;
    localparam int ROM_BANKS  = 2;
    localparam int BANK_BYTES = 16384;
    localparam int OFS_W      = $clog2(BANK_BYTES);
    localparam int RAM_DEPTH  = RAM_BANKS * BANK_BYTES;
    localparam int ROM_DEPTH  = ROM_BANKS * BANK_BYTES;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int ROM_AW     = $clog2(ROM_DEPTH);
    localparam int ROM_SEL_W  = ROM_AW - OFS_W;

    // Paging byte fields
    localparam int LOCK_BIT   = 5;
    localparam int ROMSEL_BIT = 4;

    // Fixed windows
    localparam logic [2:0] SCREEN_BANK = 3'd5;
    localparam logic [2:0] MID_BANK    = 3'd2;
    localparam logic [1:0] WIN_ROM     = 2'b00;
    localparam logic [1:0] WIN_SCREEN  = 2'b01;
    localparam logic [1:0] WIN_MID     = 2'b10;

    // Item commands; code 7 means nothing and falls to default arms
    typedef enum logic [2:0] {
        CMD_READ_B    = 3'd0,
        CMD_WRITE_B   = 3'd1,
        CMD_READ_W    = 3'd2,
        CMD_WRITE_W   = 3'd3,
        CMD_PAGE      = 3'd4,
        CMD_BANK_LOAD = 3'd5,
        CMD_ROM_LOAD  = 3'd6
    } cmd_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WORD = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch item, first byte access from ports
        logic second;   // second byte access from latched item
        logic emit;     // load result register
        logic last;     // result is the final one of the item
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic write_word;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmpu_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bmpu_ctrl.sv =====
// Controller state machine: sequences byte accesses and result strobes.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2:0]     command,
    input  wire bmpu_pkg::stat_t stat,
    output logic                busy,
    output bmpu_pkg::ctl_t      ctl
);

    bmpu_pkg::state_t state_reg;
    bmpu_pkg::state_t state_next;
    logic             is_word;

    // Word commands take a second byte access
    always_comb
    begin
        is_word = bmpu_pkg::cmd_t'(command) inside {bmpu_pkg::CMD_READ_W,
                                                   bmpu_pkg::CMD_WRITE_W};
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        case (state_reg)
            bmpu_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = is_word ? bmpu_pkg::ST_WORD : bmpu_pkg::ST_DONE;
                end
            end
            bmpu_pkg::ST_WORD:
            begin
                ctl.second = 1'b1;
                ctl.emit   = stat.write_word;
                state_next = bmpu_pkg::ST_DONE;
            end
            bmpu_pkg::ST_DONE:
            begin
                ctl.emit   = 1'b1;
                ctl.last   = 1'b1;
                state_next = bmpu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bmpu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmpu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A second access always leads to the final result
    a_word_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.second |=> (ctl.emit && ctl.last))
        else $error("second access not followed by final result");

    // A non-final result comes only from a second access
    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && !ctl.last) |-> ctl.second)
        else $error("early result outside second access");

    // An accepted item keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> busy)
        else $error("not busy after accept");

endmodule

`default_nettype wire

// ===== hw/rtl/bmpu_dp.sv =====
// Datapath: item latch, paging register, window decode, memories, result register.
`timescale 1ns / 1ps
`default_nettype none

module bmpu_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bmpu_pkg::ctl_t ctl,
    input  wire logic [2:0]     command,
    input  wire logic [15:0]    address,
    input  wire logic [15:0]    data,
    input  wire logic [2:0]     bank,
    output bmpu_pkg::stat_t     stat,
    output logic                result_valid,
    output logic [15:0]         read_data,
    output logic                video_valid,
    output logic [15:0]         video_address,
    output logic [7:0]          video_data,
    output logic                last
);

    // Latched item
    bmpu_pkg::cmd_t cmd_reg;
    logic [15:0]    addr_reg;
    logic [15:0]    data_reg;
    logic [7:0]     paging_reg;

    // Access select
    bmpu_pkg::cmd_t acc_cmd;
    logic [15:0]    acc_addr;
    logic [7:0]     acc_byte;
    logic [2:0]     win_bank;
    logic           acc_en;

    // Memory ports
    logic                          ram_we;
    logic                          ram_re;
    logic [bmpu_pkg::RAM_AW-1:0]   ram_addr;
    logic [7:0]                    ram_q;
    logic                          rom_we;
    logic                          rom_re;
    logic [bmpu_pkg::ROM_AW-1:0]   rom_addr;
    logic [7:0]                    rom_q;

    // Per-access notes
    logic        vid_v;
    logic [15:0] vid_a;
    logic        rd_rom_reg;
    logic        vid_valid_reg;
    logic [15:0] vid_addr_reg;
    logic [7:0]  vid_data_reg;
    logic [7:0]  rd_byte;
    logic [7:0]  lo_reg;

    // Result register
    logic        out_valid_reg;
    logic [15:0] out_rdata_reg;
    logic        out_vvalid_reg;
    logic [15:0] out_vaddr_reg;
    logic [7:0]  out_vdata_reg;
    logic        out_last_reg;
    logic [15:0] rdata_next;

    assign stat.write_word = (cmd_reg == bmpu_pkg::CMD_WRITE_W);
    assign acc_en          = ctl.accept | ctl.second;

    // First access comes straight from the ports, second from the latch
    always_comb
    begin
        if (ctl.accept)
        begin
            acc_cmd  = bmpu_pkg::cmd_t'(command);
            acc_addr = address;
            acc_byte = data[7:0];
        end
        else
        begin
            acc_cmd  = cmd_reg;
            acc_addr = addr_reg + 16'd1;
            acc_byte = data_reg[15:8];
        end
    end

    // Window decode of a CPU address
    always_comb
    begin
        case (acc_addr[15:14])
            bmpu_pkg::WIN_SCREEN: win_bank = bmpu_pkg::SCREEN_BANK;
            bmpu_pkg::WIN_MID:    win_bank = bmpu_pkg::MID_BANK;
            default:              win_bank = paging_reg[2:0];
        endcase
    end

    // Memory commands and video notification for this access
    always_comb
    begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        rom_we   = 1'b0;
        rom_re   = 1'b0;
        ram_addr = {win_bank, acc_addr[bmpu_pkg::OFS_W-1:0]};
        rom_addr = {paging_reg[bmpu_pkg::ROMSEL_BIT], acc_addr[bmpu_pkg::OFS_W-1:0]};
        vid_v    = 1'b0;
        vid_a    = acc_addr;
        case (acc_cmd)
            bmpu_pkg::CMD_READ_B, bmpu_pkg::CMD_READ_W:
            begin
                if (acc_addr[15:14] == bmpu_pkg::WIN_ROM)
                begin
                    rom_re = acc_en;
                end
                else
                begin
                    ram_re = acc_en;
                end
            end
            bmpu_pkg::CMD_WRITE_B, bmpu_pkg::CMD_WRITE_W:
            begin
                // ROM window writes are dropped
                ram_we = acc_en && (acc_addr[15:14] != bmpu_pkg::WIN_ROM);
                vid_v  = (acc_addr[15:14] == bmpu_pkg::WIN_SCREEN);
            end
            bmpu_pkg::CMD_BANK_LOAD:
            begin
                ram_addr = {bank, acc_addr[bmpu_pkg::OFS_W-1:0]};
                ram_we   = acc_en;
                vid_v    = (bank == bmpu_pkg::SCREEN_BANK);
                vid_a    = {bmpu_pkg::WIN_SCREEN, acc_addr[bmpu_pkg::OFS_W-1:0]};
            end
            bmpu_pkg::CMD_ROM_LOAD:
            begin
                rom_addr = {bank[bmpu_pkg::ROM_SEL_W-1:0], acc_addr[bmpu_pkg::OFS_W-1:0]};
                rom_we   = acc_en && (bank < 3'(bmpu_pkg::ROM_BANKS));
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    bmpu_ram #(
        .WIDTH (8),
        .DEPTH (bmpu_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (acc_byte),
        .rdata (ram_q)
    );

    bmpu_ram #(
        .WIDTH (8),
        .DEPTH (bmpu_pkg::ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .re    (rom_re),
        .addr  (rom_addr),
        .wdata (acc_byte),
        .rdata (rom_q)
    );

    assign rd_byte = rd_rom_reg ? rom_q : ram_q;

    // Item latch and per-access notes
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= bmpu_pkg::cmd_t'(command);
            addr_reg <= address;
            data_reg <= data;
        end
        if (acc_en)
        begin
            rd_rom_reg    <= rom_re;
            vid_valid_reg <= vid_v;
            vid_addr_reg  <= vid_v ? vid_a : 16'h0000;
            vid_data_reg  <= vid_v ? acc_byte : 8'h00;
        end
        if (ctl.second)
        begin
            lo_reg <= rd_byte;
        end
    end

    // Paging register, frozen once locked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_reg <= '0;
        end
        else if (ctl.accept && (bmpu_pkg::cmd_t'(command) == bmpu_pkg::CMD_PAGE)
                 && !paging_reg[bmpu_pkg::LOCK_BIT])
        begin
            paging_reg <= data[7:0];
        end
    end

    // Read data of the result
    always_comb
    begin
        case (cmd_reg)
            bmpu_pkg::CMD_READ_B: rdata_next = {8'h00, rd_byte};
            bmpu_pkg::CMD_READ_W: rdata_next = {rd_byte, lo_reg};
            default:              rdata_next = 16'h0000;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_rdata_reg  <= ctl.last ? rdata_next : 16'h0000;
            out_vvalid_reg <= vid_valid_reg;
            out_vaddr_reg  <= vid_addr_reg;
            out_vdata_reg  <= vid_data_reg;
            out_last_reg   <= ctl.last;
        end
    end

    assign result_valid  = out_valid_reg;
    assign read_data     = out_rdata_reg;
    assign video_valid   = out_vvalid_reg;
    assign video_address = out_vaddr_reg;
    assign video_data    = out_vdata_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/banked_memory_paging_unit.sv =====
// Top level of the banked memory paging unit.
//
// Start an item by raising start while busy is low; command, address, data and bank are
// sampled at that edge. Busy stays high through the DONE state for byte commands and
// through the WORD and DONE states for word commands: each byte is one access to a
// single-port RAM or ROM store, and a word needs two. Results appear on the result
// ports for exactly one cycle marked by result_valid and cannot be held off; a word write
// gives two results on consecutive cycles, every other command one, and last marks the
// final one. The last result shows in the cycle busy drops, so the next item may start
// then. Paging writes take effect for the next item; once the lock bit is set, later
// paging writes are ignored until reset. The RAM and ROM stores are not cleared at reset;
// read only bytes that were written.
`timescale 1ns / 1ps
`default_nettype none

module banked_memory_paging_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [15:0] data,
    input  wire logic [2:0]  bank,
    output logic             result_valid,
    output logic [15:0]      read_data,
    output logic             video_valid,
    output logic [15:0]      video_address,
    output logic [7:0]       video_data,
    output logic             last
);

    bmpu_pkg::ctl_t  ctl;
    bmpu_pkg::stat_t stat;

    bmpu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .busy    (busy),
        .ctl     (ctl)
    );

    bmpu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .command       (command),
        .address       (address),
        .data          (data),
        .bank          (bank),
        .stat          (stat),
        .result_valid  (result_valid),
        .read_data     (read_data),
        .video_valid   (video_valid),
        .video_address (video_address),
        .video_data    (video_data),
        .last          (last)
    );

    // The first result of a word write is followed at once by the final one
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> (result_valid && last))
        else $error("first result not followed by final result");

    // A final result is never followed directly by another result
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result right after final result");

    // Every result is produced while the item is still in flight
    a_owned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in flight");

endmodule

`default_nettype wire

// ===== tb/sv/banked_memory_paging_checker.sv =====
// Result predictor and comparator for the banked memory paging unit.
`timescale 1ns / 1ps

module banked_memory_paging_checker
    import bmpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] address,
    input  logic [15:0] data,
    input  logic [2:0]  bank,
    input  logic        result_valid,
    input  logic [15:0] read_data,
    input  logic        video_valid,
    input  logic [15:0] video_address,
    input  logic [7:0]  video_data,
    input  logic        last,
    output int          errors,
    output int          pending,
    output int          results_checked
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] rd;
        logic        vv;
        logic [15:0] va;
        logic [7:0]  vd;
        logic        fin;
    } mem_result_t;

    // Expected results in issue order
    mem_result_t expected_results [$];

    // Own copy of the memory image and paging byte
    logic [7:0] ram_img [RAM_DEPTH];
    logic [7:0] rom_img [ROM_DEPTH];
    logic [7:0] paging_byte = 8'h00;

    int fail_count = 0;
    int checked    = 0;

    initial begin
        errors          = 0;
        pending         = 0;
        results_checked = 0;
    end

    // RAM slot behind a CPU address above the ROM window
    function automatic logic [RAM_AW-1:0] ram_slot(input logic [15:0] a);
        logic [2:0] b;
        case (a[15:14])
            WIN_SCREEN: b = SCREEN_BANK;
            WIN_MID:    b = MID_BANK;
            default:    b = paging_byte[2:0];
        endcase
        return {b, a[OFS_W-1:0]};
    endfunction

    function automatic logic [7:0] cpu_fetch(input logic [15:0] a);
        if (a[15:14] == WIN_ROM)
            return rom_img[{paging_byte[ROMSEL_BIT], a[OFS_W-1:0]}];
        return ram_img[ram_slot(a)];
    endfunction

    // CPU byte write; ROM window is dropped, screen window notifies
    function automatic mem_result_t cpu_store(input logic [15:0] a, input logic [7:0] v);
        mem_result_t r;
        r = '0;
        if (a[15:14] != WIN_ROM) begin
            ram_img[ram_slot(a)] = v;
            if (a[15:14] == WIN_SCREEN) begin
                r.vv = 1'b1;
                r.va = a;
                r.vd = v;
            end
        end
        return r;
    endfunction

    // Work out the results of one accepted item and queue them
    task automatic predict_item(input logic [2:0] c, input logic [15:0] a,
                                input logic [15:0] d, input logic [2:0] b);
        mem_result_t r0;
        mem_result_t r1;
        r0 = '0;
        r1 = '0;
        case (c)
            CMD_READ_B:  r0.rd = {8'h00, cpu_fetch(a)};
            CMD_WRITE_B: r0 = cpu_store(a, d[7:0]);
            CMD_READ_W:  r0.rd = {cpu_fetch(a + 16'd1), cpu_fetch(a)};
            CMD_WRITE_W: begin
                r0 = cpu_store(a, d[7:0]);
                r1 = cpu_store(a + 16'd1, d[15:8]);
            end
            CMD_PAGE: begin
                if (!paging_byte[LOCK_BIT])
                    paging_byte = d[7:0];
            end
            CMD_BANK_LOAD: begin
                ram_img[{b, a[OFS_W-1:0]}] = d[7:0];
                if (b == SCREEN_BANK) begin
                    r0.vv = 1'b1;
                    r0.va = {WIN_SCREEN, a[OFS_W-1:0]};
                    r0.vd = d[7:0];
                end
            end
            CMD_ROM_LOAD: begin
                if (b < 3'(ROM_BANKS))
                    rom_img[{b[ROM_SEL_W-1:0], a[OFS_W-1:0]}] = d[7:0];
            end
            default: ;
        endcase
        if (c == CMD_WRITE_W) begin
            r1.fin = 1'b1;
            expected_results.push_back(r0);
            expected_results.push_back(r1);
        end else begin
            r0.fin = 1'b1;
            expected_results.push_back(r0);
        end
    endtask

    // Compare results, then take in new items
    always @(posedge clk) begin
        mem_result_t got;
        mem_result_t want;
        if (rst_n) begin
            if (result_valid) begin
                got = {read_data, video_valid, video_address, video_data, last};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with none expected: rd %h vv %b va %h vd %h last %b",
                                 $realtime, got.rd, got.vv, got.va, got.vd, got.fin);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch exp rd %h vv %b va %h vd %h last %b / got rd %h vv %b va %h vd %h last %b",
                                     $realtime, want.rd, want.vv, want.va, want.vd, want.fin,
                                     got.rd, got.vv, got.va, got.vd, got.fin);
                    end
                end
            end
            if (start && !busy)
                predict_item(command, address, data, bank);
            errors          <= fail_count;
            pending         <= expected_results.size();
            results_checked <= checked;
        end
    end

endmodule

// ===== tb/sv/tb_banked_memory_paging_unit.sv =====
// Top of the banked memory paging unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_banked_memory_paging_unit;
    import bmpu_pkg::*;

    localparam logic [2:0]  CMD_UNUSED    = 3'd7;
    localparam logic [15:0] LOCK_MASK     = 16'h0001 << LOCK_BIT;
    localparam int          RANDOM_ITEMS  = 1880;
    localparam int          LOCKED_ITEMS  = 100;
    localparam int          DRAIN_EVERY   = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 300000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic [2:0]  command       = '0;
    logic [15:0] address       = '0;
    logic [15:0] data          = '0;
    logic [2:0]  bank          = '0;
    logic        busy;
    logic        result_valid;
    logic [15:0] read_data;
    logic        video_valid;
    logic [15:0] video_address;
    logic [7:0]  video_data;
    logic        last;

    int errors;
    int pending;
    int results_checked;

    // Which bytes hold data, so reads never touch an unwritten byte
    bit          ram_seen [RAM_DEPTH];
    bit          rom_seen [ROM_DEPTH];
    logic [7:0]  page_shadow = 8'h00;
    logic [13:0] hot_offsets [16];

    int cycle_count = 0;
    int burst_left  = 0;
    int cmd_tally [8];

    always #4 clk = ~clk;

    banked_memory_paging_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .address       (address),
        .data          (data),
        .bank          (bank),
        .result_valid  (result_valid),
        .read_data     (read_data),
        .video_valid   (video_valid),
        .video_address (video_address),
        .video_data    (video_data),
        .last          (last)
    );

    banked_memory_paging_checker paging_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .address         (address),
        .data            (data),
        .bank            (bank),
        .result_valid    (result_valid),
        .read_data       (read_data),
        .video_valid     (video_valid),
        .video_address   (video_address),
        .video_data      (video_data),
        .last            (last),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Run time guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[banked_memory_paging_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [2:0] shadow_bank(input logic [15:0] a);
        case (a[15:14])
            WIN_SCREEN: return SCREEN_BANK;
            WIN_MID:    return MID_BANK;
            default:    return page_shadow[2:0];
        endcase
    endfunction

    function automatic bit byte_known(input logic [15:0] a);
        if (a[15:14] == WIN_ROM)
            return rom_seen[{page_shadow[ROMSEL_BIT], a[OFS_W-1:0]}];
        return ram_seen[{shadow_bank(a), a[OFS_W-1:0]}];
    endfunction

    task automatic mark_written(input logic [15:0] a);
        if (a[15:14] != WIN_ROM)
            ram_seen[{shadow_bank(a), a[OFS_W-1:0]}] = 1'b1;
    endtask

    // Present one item and hold it until the block takes it
    task automatic issue(input logic [2:0] c, input logic [15:0] a,
                         input logic [15:0] d, input logic [2:0] b);
        command <= c;
        address <= a;
        data    <= d;
        bank    <= b;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cmd_tally[c]++;
        case (c)
            CMD_WRITE_B: mark_written(a);
            CMD_WRITE_W: begin
                mark_written(a);
                mark_written(a + 16'd1);
            end
            CMD_PAGE: begin
                if (!page_shadow[LOCK_BIT])
                    page_shadow = d[7:0];
            end
            CMD_BANK_LOAD: ram_seen[{b, a[OFS_W-1:0]}] = 1'b1;
            CMD_ROM_LOAD: begin
                if (b < 3'(ROM_BANKS))
                    rom_seen[{b[ROM_SEL_W-1:0], a[OFS_W-1:0]}] = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Bursts of back-to-back items with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending until every expected result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // One random item; reads of unknown bytes become loads of those bytes
    task automatic random_item(input bit allow_lock);
        logic [2:0]  c;
        logic [15:0] a;
        logic [15:0] d;
        logic [2:0]  b;
        logic [15:0] miss;
        logic [13:0] o;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 20)      c = CMD_READ_B;
        else if (r < 35) c = CMD_WRITE_B;
        else if (r < 50) c = CMD_READ_W;
        else if (r < 65) c = CMD_WRITE_W;
        else if (r < 70) c = CMD_PAGE;
        else if (r < 85) c = CMD_BANK_LOAD;
        else if (r < 97) c = CMD_ROM_LOAD;
        else             c = CMD_UNUSED;

        if ($urandom_range(0, 3) == 0) begin
            a = 16'($urandom);
        end else begin
            o = hot_offsets[$urandom_range(0, 15)];
            if ($urandom_range(0, 1))
                o = o + 14'd1;
            a = {2'($urandom_range(0, 3)), o};
        end
        d = 16'($urandom);
        b = 3'($urandom_range(0, 7));
        if (c == CMD_ROM_LOAD && $urandom_range(0, 4) != 0)
            b = 3'($urandom_range(0, 1));
        if (c == CMD_PAGE && !allow_lock)
            d = d & ~LOCK_MASK;

        if ((c == CMD_READ_B || c == CMD_READ_W) &&
            (!byte_known(a) || (c == CMD_READ_W && !byte_known(a + 16'd1)))) begin
            miss = byte_known(a) ? a + 16'd1 : a;
            if (miss[15:14] == WIN_ROM) begin
                c = CMD_ROM_LOAD;
                b = {2'b00, page_shadow[ROMSEL_BIT]};
                a = {2'($urandom_range(0, 3)), miss[OFS_W-1:0]};
            end else begin
                c = CMD_BANK_LOAD;
                b = shadow_bank(miss);
                a = miss;
            end
        end
        issue(c, a, d, b);
    endtask

    initial begin
        int n;
        foreach (hot_offsets[i])
            hot_offsets[i] = 14'($urandom);
        hot_offsets[0] = '0;
        hot_offsets[1] = '1;
        foreach (cmd_tally[i])
            cmd_tally[i] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: loads, window edges, word wrap, paging, unused code
        issue(CMD_ROM_LOAD,  16'h0000, 16'h12A5, 3'd0);
        issue(CMD_ROM_LOAD,  16'hFFFF, 16'hFF3C, 3'd0);   // only offset bits count
        issue(CMD_ROM_LOAD,  16'hC000, 16'h0077, 3'd1);
        issue(CMD_ROM_LOAD,  16'h0000, 16'h00FF, 3'd2);   // no such ROM bank
        issue(CMD_ROM_LOAD,  16'h0001, 16'hFFFF, 3'd7);
        issue(CMD_WRITE_B,   16'h4000, 16'hAB55, 3'd0);   // screen byte
        issue(CMD_WRITE_B,   16'h1234, 16'h00EE, 3'd7);   // ROM window, dropped
        issue(CMD_WRITE_B,   16'h8000, 16'h00C3, 3'd0);   // just past screen
        issue(CMD_WRITE_W,   16'h7FFF, 16'hBEEF, 3'd0);   // straddles screen end
        issue(CMD_WRITE_W,   16'hFFFF, 16'h1357, 3'd0);   // wraps into ROM
        issue(CMD_WRITE_W,   16'h3FFF, 16'h2468, 3'd0);   // ROM then screen
        issue(CMD_READ_B,    16'h0000, 16'h0000, 3'd0);
        issue(CMD_READ_W,    16'h3FFF, 16'hFFFF, 3'd7);
        issue(CMD_READ_W,    16'hFFFF, 16'h0000, 3'd0);
        issue(CMD_READ_W,    16'h7FFF, 16'h0000, 3'd0);
        issue(CMD_BANK_LOAD, 16'hFFFF, 16'h0099, 3'd5);   // loader hits screen
        issue(CMD_BANK_LOAD, 16'h0000, 16'hFFFF, 3'd7);
        issue(CMD_PAGE,      16'h0000, 16'h001F, 3'd0);   // bank 7, ROM 1, bit 3
        issue(CMD_READ_B,    16'hC000, 16'h0000, 3'd0);
        issue(CMD_READ_B,    16'h0000, 16'h0000, 3'd0);
        issue(CMD_PAGE,      16'hFFFF, 16'hFF05, 3'd7);   // bank 5 at top window
        issue(CMD_WRITE_B,   16'hC001, 16'h005A, 3'd0);   // screen bank, no notify
        issue(CMD_READ_B,    16'h4001, 16'h0000, 3'd0);
        issue(CMD_PAGE,      16'h0000, 16'h0000, 3'd0);
        issue(CMD_UNUSED,    16'hFFFF, 16'hFFFF, 3'd7);
        drain();

        // Random traffic with the lock held clear
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            random_item(1'b0);
            pace();
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain();
        end
        drain();

        // Engage the lock, then keep going with unrestricted paging data
        issue(CMD_PAGE, 16'($urandom), 16'($urandom) | LOCK_MASK,
              3'($urandom_range(0, 7)));
        for (n = 0; n < LOCKED_ITEMS; n++) begin
            random_item(1'b1);
            pace();
        end
        drain();

        $display("Sent %0d reads, %0d writes, %0d paging writes, %0d loads, %0d unused codes",
                 cmd_tally[CMD_READ_B] + cmd_tally[CMD_READ_W],
                 cmd_tally[CMD_WRITE_B] + cmd_tally[CMD_WRITE_W], cmd_tally[CMD_PAGE],
                 cmd_tally[CMD_BANK_LOAD] + cmd_tally[CMD_ROM_LOAD], cmd_tally[CMD_UNUSED]);
        $display("Checked %0d results, last %0d items with the paging lock set",
                 results_checked, LOCKED_ITEMS);
        if (errors == 0 && pending == 0)
            $display("[banked_memory_paging_unit] OK");
        else
            $display("[banked_memory_paging_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_ram.sv
hw/rtl/bmpu_ctrl.sv
hw/rtl/bmpu_dp.sv
hw/rtl/banked_memory_paging_unit.sv
tb/sv/banked_memory_paging_checker.sv
tb/sv/tb_banked_memory_paging_unit.sv
